// File: src/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg
// shared types and constants of the rgb to hsv pixel pipeline
// ----------------------------------------------------------------------------
package rhsv_pkg;

    localparam int CHAN_W = 8;
    localparam int REM_W  = 16;
    localparam int NUM_W  = 12;
    localparam int DIV_STEPS = 8;

    localparam logic [CHAN_W-1:0] HUE_SCALE = 8'd30;
    localparam logic [CHAN_W-1:0] FULL_TURN = 8'd6;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic [REM_W-1:0]  hue_rem;
        logic [CHAN_W-1:0] hue_div;
        logic [REM_W-1:0]  sat_rem;
        logic [CHAN_W-1:0] sat_div;
        logic [CHAN_W-1:0] hue_q;
        logic [CHAN_W-1:0] sat_q;
        logic [CHAN_W-1:0] bright;
        logic              last;
    } t_stage;

endpackage

// File: src/rhsv_div_stage.sv
// ----------------------------------------------------------------------------
// rhsv_div_stage
// one registered restoring-division step for hue and saturation
// ----------------------------------------------------------------------------
module rhsv_div_stage
    import rhsv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_stage i_in_data,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_stage o_out_data
);

    logic         r_valid;
    t_stage       r_data;
    t_stage       n_data;
    logic [8:0]   hue_sub;
    logic [8:0]   sat_sub;
    logic         hue_bit;
    logic         sat_bit;

    assign o_in_ready  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_comb begin
        hue_sub = i_in_data.hue_rem[REM_W-1:REM_W-9] - {1'b0, i_in_data.hue_div};
        sat_sub = i_in_data.sat_rem[REM_W-1:REM_W-9] - {1'b0, i_in_data.sat_div};
        hue_bit = i_in_data.hue_rem[REM_W-1:REM_W-9] >= {1'b0, i_in_data.hue_div};
        sat_bit = i_in_data.sat_rem[REM_W-1:REM_W-9] >= {1'b0, i_in_data.sat_div};
        n_data  = i_in_data;
        if (hue_bit) begin
            n_data.hue_rem = {hue_sub[7:0], i_in_data.hue_rem[6:0], 1'b0};
        end else begin
            n_data.hue_rem = {i_in_data.hue_rem[REM_W-2:0], 1'b0};
        end
        if (sat_bit) begin
            n_data.sat_rem = {sat_sub[7:0], i_in_data.sat_rem[6:0], 1'b0};
        end else begin
            n_data.sat_rem = {i_in_data.sat_rem[REM_W-2:0], 1'b0};
        end
        n_data.hue_q = {i_in_data.hue_q[CHAN_W-2:0], hue_bit};
        n_data.sat_q = {i_in_data.sat_q[CHAN_W-2:0], sat_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: src/rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// pipelined 8-bit rgb to hsv converter, hue in units of two degrees
// ----------------------------------------------------------------------------
// usage:
//   input stream carries one rgb pixel per item on i_s_tdata, with tlast
//   marking the final pixel of an image; output stream carries hue,
//   saturation and brightness on o_m_tdata with the tlast copied across.
//   one item per cycle while i_m_tready is high; pixels are independent.
//   the pipeline has one stage for max, min and sector, one for the
//   hue numerator and the scaled products, then eight division stages,
//   one quotient bit each, shared by the hue and saturation dividers.
//   the last division stage is the output register.
//   each stage holds its item while the next one is full and stalled, so
//   a stall on i_m_tready fills the empty stages first and then drops
//   o_s_tready; nothing is lost or repeated.
//   synchronous active-low reset empties every stage; no item is pending
//   after reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel
    import rhsv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red, green, blue
    input  logic        i_s_tlast,   // last_pixel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // hue, saturation, brightness
    output logic        o_m_tlast    // last_out
);

    logic [CHAN_W-1:0] in_r, in_g, in_b, in_mx, in_mn;
    logic [1:0]        in_sec;

    logic              r_a_valid;
    logic [CHAN_W-1:0] r_a_r, r_a_g, r_a_b, r_a_mx, r_a_delta;
    logic [1:0]        r_a_sec;
    logic              r_a_last;
    logic              a_ready;

    logic              r_b_valid;
    t_stage            r_b_data;
    t_stage            n_b_data;
    logic              b_ready;
    logic [NUM_W-1:0]  num;
    logic [REM_W-1:0]  num_w;
    logic [REM_W-1:0]  delta_w;

    logic              st_valid [DIV_STEPS+1];
    logic              st_ready [DIV_STEPS+1];
    t_stage            st_data  [DIV_STEPS+1];

    // max, min and sector, blue over green over red
    always_comb begin
        in_r   = i_s_tdata[7:0];
        in_g   = i_s_tdata[15:8];
        in_b   = i_s_tdata[23:16];
        in_mx  = (in_r > in_g) ? in_r : in_g;
        in_mx  = (in_mx > in_b) ? in_mx : in_b;
        in_mn  = (in_r < in_g) ? in_r : in_g;
        in_mn  = (in_mn < in_b) ? in_mn : in_b;
        if (in_mx == in_b) begin
            in_sec = SEC_BLUE;
        end else if (in_mx == in_g) begin
            in_sec = SEC_GREEN;
        end else begin
            in_sec = SEC_RED;
        end
    end

    assign a_ready    = !r_a_valid || b_ready;
    assign o_s_tready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_s_tvalid) begin
            r_a_r     <= in_r;
            r_a_g     <= in_g;
            r_a_b     <= in_b;
            r_a_mx    <= in_mx;
            r_a_delta <= in_mx - in_mn;
            r_a_sec   <= in_sec;
            r_a_last  <= i_s_tlast;
        end
    end

    // hue numerator and the two scaled dividends
    always_comb begin
        case (r_a_sec)
            SEC_BLUE: begin
                num = {2'd0, r_a_delta, 2'b00} + {4'd0, r_a_r} - {4'd0, r_a_g};
            end
            SEC_GREEN: begin
                num = {3'd0, r_a_delta, 1'b0} + {4'd0, r_a_b} - {4'd0, r_a_r};
            end
            default: begin
                if (r_a_g < r_a_b) begin
                    num = {4'd0, r_a_delta} * {4'd0, FULL_TURN}
                        - ({4'd0, r_a_b} - {4'd0, r_a_g});
                end else begin
                    num = {4'd0, r_a_g} - {4'd0, r_a_b};
                end
            end
        endcase
        num_w   = {{(REM_W-NUM_W){1'b0}}, num};
        delta_w = {8'd0, r_a_delta};
        n_b_data.hue_rem = num_w * {8'd0, HUE_SCALE};
        n_b_data.hue_div = (r_a_delta == '0) ? 8'd1 : r_a_delta;
        n_b_data.sat_rem = {r_a_delta, 8'd0} - delta_w;
        n_b_data.sat_div = (r_a_mx == '0) ? 8'd1 : r_a_mx;
        n_b_data.hue_q   = '0;
        n_b_data.sat_q   = '0;
        n_b_data.bright  = r_a_mx;
        n_b_data.last    = r_a_last;
    end

    assign b_ready = !r_b_valid || st_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

    assign st_valid[0] = r_b_valid;
    assign st_data[0]  = r_b_data;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        rhsv_div_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_in_valid  (st_valid[k]),
            .o_in_ready  (st_ready[k]),
            .i_in_data   (st_data[k]),
            .o_out_valid (st_valid[k+1]),
            .i_out_ready (st_ready[k+1]),
            .o_out_data  (st_data[k+1])
        );
    end

    assign st_ready[DIV_STEPS] = i_m_tready;

    assign o_m_tvalid = st_valid[DIV_STEPS];
    assign o_m_tdata  = {st_data[DIV_STEPS].bright,
                         st_data[DIV_STEPS].sat_q,
                         st_data[DIV_STEPS].hue_q};
    assign o_m_tlast  = st_data[DIV_STEPS].last;

endmodule

// File: test/rgb_to_hsv_pixel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_tb
// self-checking bench for the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
// drives pixels on the input stream, predicts hue, saturation and brightness
// for every accepted item and compares each output item in order against
// the prediction; a directed set covers black, white, grey, pure colors and
// ties between channels, then random pixels follow with random gaps on the
// input side and random stalls on the output side
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_tb;

    localparam int N_RANDOM    = 1900;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    class hsv_scoreboard;
        typedef struct {
            logic [7:0] hue;
            logic [7:0] sat;
            logic [7:0] bright;
            logic       last;
        } t_hsv_item;

        t_hsv_item expected_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
            t_hsv_item item;
            int mx;
            int mn;
            int delta;
            int num;
            int hue;
            mx = (r > g) ? r : g;
            mx = (mx > b) ? mx : b;
            mn = (r < g) ? r : g;
            mn = (mn < b) ? mn : b;
            delta = mx - mn;
            hue = 0;
            if (delta != 0) begin
                // blue wins ties over green, green over red
                if (mx == b) begin
                    num = 4 * delta + r - g;
                end else if (mx == g) begin
                    num = 2 * delta + b - r;
                end else begin
                    num = g - b;
                    if (g < b) begin
                        num += 6 * delta;
                    end
                end
                if (num < 0) begin
                    num = 0;
                end
                hue = (30 * num) / delta;
                if (hue > 179) begin
                    hue = 179;
                end
            end
            item.hue    = hue[7:0];
            item.sat    = (mx != 0) ? 8'((255 * delta) / mx) : 8'd0;
            item.bright = mx[7:0];
            item.last   = last;
            expected_q.push_back(item);
        endfunction

        task check_result(logic [23:0] data, logic last);
            t_hsv_item item;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item", data, 0);
            end else begin
                item = expected_q.pop_front();
                if (data[7:0] !== item.hue) begin
                    report_mismatch("hue", data[7:0], item.hue);
                end
                if (data[15:8] !== item.sat) begin
                    report_mismatch("saturation", data[15:8], item.sat);
                end
                if (data[23:16] !== item.bright) begin
                    report_mismatch("brightness", data[23:16], item.bright);
                end
                if (last !== item.last) begin
                    report_mismatch("last", last, item.last);
                end
            end
        endtask
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;   // red, green, blue
    logic        i_s_tlast  = 1'b0; // last_pixel
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;         // hue, saturation, brightness
    logic        o_m_tlast;         // last_out

    hsv_scoreboard sb = new();
    int  cycle_cnt = 0;
    bit  src_steady = 1'b0;

    rgb_to_hsv_pixel u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // output side: random stalls, none in a long window
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (src_steady) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= 21);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata, o_m_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, g, r};
        i_s_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!(i_s_tvalid && o_s_tready));
        sb.note_pixel(r, g, b, last);
        while (!src_steady && $urandom_range(99) < 21) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task send_random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] v;
        logic       last;
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        v = 8'($urandom_range(255));
        last = ($urandom_range(15) == 0);
        case ($urandom_range(7))
            0: begin
                r = v;
                g = v;
                b = v;
            end
            1: begin
                case ($urandom_range(2))
                    0: g = r;
                    1: b = g;
                    default: b = r;
                endcase
            end
            2: begin
                r = $urandom_range(1) ? 8'd255 : 8'd0;
                b = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            default: begin
            end
        endcase
        send_pixel(r, g, b, last);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // black, white, grey
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd1,   8'd1,   8'd1,   1'b0);
        // pure colors and secondaries
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b1);
        // red maximum with green below blue wraps around
        send_pixel(8'd255, 8'd0,   8'd1,   1'b0);
        send_pixel(8'd200, 8'd10,  8'd100, 1'b0);
        send_pixel(8'd200, 8'd100, 8'd10,  1'b0);
        // ties at the maximum
        send_pixel(8'd200, 8'd200, 8'd50,  1'b0);
        send_pixel(8'd50,  8'd200, 8'd200, 1'b0);
        send_pixel(8'd200, 8'd50,  8'd200, 1'b0);
        // smallest deltas and maxima
        send_pixel(8'd1,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd1,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd1,   1'b0);
        send_pixel(8'd255, 8'd254, 8'd254, 1'b0);
        send_pixel(8'd254, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd254, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd254, 1'b1);
        send_pixel(8'd170, 8'd85,  8'd42,  1'b0);

        for (int i = 0; i < N_RANDOM; i++) begin
            src_steady = (i >= 600 && i < 900);
            send_random_pixel();
        end
        src_steady = 1'b0;
        i_s_tvalid <= 1'b0;

        while (sb.pending() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
src/rhsv_pkg.sv
src/rhsv_div_stage.sv
src/rgb_to_hsv_pixel.sv
test/rgb_to_hsv_pixel_tb.sv
